// ===== hdl/clc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and constants for the centred linear convolution block.
// ----------------------------------------------------------------------------
package clc_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int VALUE_W  = 38;
    localparam int INDEX_W  = 6;
    localparam int CFG_W    = 7;

    // Reset value of the length register
    localparam logic [CFG_W-1:0] LENGTH_RESET = 7'd64;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } seq_state_t;

    // One multiply-accumulate term as it travels down the datapath
    typedef struct packed {
        logic               valid;    // term present in this stage
        logic               en;       // term lies inside the sequence
        logic               first;    // first term of a result
        logic               last;     // last term of a result
        logic               run_end;  // last result of the run
        logic [INDEX_W-1:0] index;    // result position
    } term_t;

endpackage
`default_nettype wire

// ===== hdl/clc_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clc_store
// Two sample memories, one write port and one registered read port each.
// ----------------------------------------------------------------------------
module clc_store
    import clc_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic signed [SAMPLE_W-1:0] wr_first,
    input  wire logic signed [SAMPLE_W-1:0] wr_second,
    input  wire logic [ADDR_W-1:0]          rd_addr_first,
    input  wire logic [ADDR_W-1:0]          rd_addr_second,
    output logic signed [SAMPLE_W-1:0]      rd_first,
    output logic signed [SAMPLE_W-1:0]      rd_second
);

    logic signed [SAMPLE_W-1:0] first_mem  [DEPTH];
    logic signed [SAMPLE_W-1:0] second_mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            first_mem[wr_addr]  <= wr_first;
            second_mem[wr_addr] <= wr_second;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rd_first  <= first_mem[rd_addr_first];
        rd_second <= second_mem[rd_addr_second];
    end

endmodule
`default_nettype wire

// ===== hdl/clc_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clc_seq
// Load counter, length register and the (x, j) term sequencer.
// ----------------------------------------------------------------------------
module clc_seq
    import clc_pkg::*;
#(
    parameter int MAX_LENGTH = 64,
    parameter int IDX_W      = 6,
    parameter int LEN_W      = 7
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             cfg_valid,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             mac_active,
    output logic                  busy,
    output logic                  cfg_ready,
    output logic [IDX_W-1:0]      load_slot,
    output logic [IDX_W-1:0]      rd_addr_first,
    output logic [IDX_W-1:0]      rd_addr_second,
    output term_t                 term
);

    localparam int CTR_W = IDX_W + 1;

    seq_state_t       state_reg, state_next;
    logic [CFG_W-1:0] length_cfg_reg;
    logic [IDX_W-1:0] load_count_reg, load_count_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] len_m1_reg, len_m1_next;
    logic [IDX_W-1:0] half_reg, half_next;
    logic [IDX_W-1:0] x_reg, x_next;
    logic [IDX_W-1:0] j_reg, j_next;

    logic [LEN_W-1:0] eff_len;
    logic             accept;
    logic             run_done;
    logic [CTR_W-1:0] centre;
    logic [CTR_W-1:0] offset;
    logic             last_j;
    logic             last_x;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = ~busy;
    assign accept    = start & ~busy;
    assign load_slot = load_count_reg;

    // Length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_cfg_reg <= LENGTH_RESET;
        else if (cfg_valid && cfg_ready)
            length_cfg_reg <= cfg_data;
    end

    // Effective length: zero acts as one, oversize clamps to the store depth
    always_comb
    begin
        if (length_cfg_reg == '0)
            eff_len = LEN_W'(1);
        else if (length_cfg_reg > CFG_W'(MAX_LENGTH))
            eff_len = LEN_W'(MAX_LENGTH);
        else
            eff_len = LEN_W'(length_cfg_reg);
    end

    // Load completes and a run starts when this beat reaches or passes the last slot
    assign run_done = ((LEN_W'(load_count_reg) + LEN_W'(1)) >= eff_len);

    // Term address generation
    assign centre = CTR_W'(x_reg) + CTR_W'(half_reg);
    assign offset = centre - CTR_W'(j_reg);
    assign last_j = (j_reg == len_m1_reg);
    assign last_x = (x_reg == len_m1_reg);

    assign rd_addr_first  = j_reg;
    assign rd_addr_second = offset[IDX_W-1:0];

    always_comb
    begin
        term.valid   = (state_reg == ST_RUN);
        term.en      = (CTR_W'(j_reg) <= centre) && (offset < CTR_W'(len_reg));
        term.first   = (j_reg == '0);
        term.last    = last_j;
        term.run_end = last_x;
        term.index   = INDEX_W'(x_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        len_next        = len_reg;
        len_m1_next     = len_m1_reg;
        half_next       = half_reg;
        x_next          = x_reg;
        j_next          = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (run_done)
                    begin
                        load_count_next = '0;
                        len_next        = eff_len;
                        len_m1_next     = IDX_W'(eff_len - LEN_W'(1));
                        half_next       = IDX_W'(eff_len >> 1);
                        x_next          = '0;
                        j_next          = '0;
                        state_next      = ST_RUN;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + IDX_W'(1);
                    end
                end
            end
            ST_RUN:
            begin
                if (last_j)
                begin
                    j_next = '0;
                    if (last_x)
                        state_next = ST_DRAIN;
                    else
                        x_next = x_reg + IDX_W'(1);
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!mac_active)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        len_m1_reg <= len_m1_next;
        half_reg   <= half_next;
        x_reg      <= x_next;
        j_reg      <= j_next;
    end

endmodule
`default_nettype wire

// ===== hdl/clc_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clc_mac
// Shared multiply-accumulate unit: read align, multiply, accumulate, emit.
// ----------------------------------------------------------------------------
module clc_mac
    import clc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire term_t                      term,
    input  wire logic signed [SAMPLE_W-1:0] rd_first,
    input  wire logic signed [SAMPLE_W-1:0] rd_second,
    output logic                            mac_active,
    output logic                            result_strobe,
    output logic [INDEX_W-1:0]              result_index,
    output logic signed [VALUE_W-1:0]       result_value,
    output logic                            last_result
);

    term_t                      s1_reg, s2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [VALUE_W-1:0]  acc_reg;
    logic signed [VALUE_W-1:0]  acc_next;

    assign mac_active = s1_reg.valid | s2_reg.valid;

    // Stage flags; s1 lines up with the registered memory data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= term;
            s2_reg <= s1_reg;
        end
    end

    // Multiply, out-of-range terms contribute zero
    always_ff @(posedge clk)
    begin
        if (s1_reg.en)
            prod_reg <= rd_first * rd_second;
        else
            prod_reg <= '0;
    end

    // Accumulate
    assign acc_next = (s2_reg.first ? VALUE_W'(0) : acc_reg) + VALUE_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (s2_reg.valid)
            acc_reg <= acc_next;
    end

    // Result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_strobe <= 1'b0;
        else
            result_strobe <= s2_reg.valid & s2_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (s2_reg.valid && s2_reg.last)
        begin
            result_index <= s2_reg.index;
            result_value <= acc_next;
            last_result  <= s2_reg.run_end;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/centered_linear_convolution.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// centered_linear_convolution
// Centred (same-size) linear convolution of two loaded Q1.15 sequences.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one sample pair per beat, taken when start is high and busy low.
//   Pairs fill both stores in order; the pair that reaches the programmed
//   length starts a run and raises busy.
//   Config: cfg_valid/cfg_ready write sequence_length (0 acts as 1, values
//   above MAX_LENGTH act as MAX_LENGTH); ready only while busy is low.
//   Output: each result is on result_index/result_value/last_result for one
//   cycle with result_strobe high; last_result marks the final one.
//   The receiver cannot stall; results are never held.
// Timing:
//   A run uses one shared 16x16 multiplier and accumulator for all
//   length*length terms, one per cycle; busy stays high until the last
//   term has left the multiply-accumulate pipeline, so no new pair is
//   taken during a run. Result x follows once its length terms are summed.
// Reset:
//   Clears the load counter, sequencer and pipeline, and sets the length
//   to 64. Store contents are undefined until written.
// ----------------------------------------------------------------------------
module centered_linear_convolution
    import clc_pkg::*;
#(
    parameter int MAX_LENGTH = 64
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [SAMPLE_W-1:0] first_sample,
    input  wire logic signed [SAMPLE_W-1:0] second_sample,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_W-1:0]           cfg_data,
    output logic                            result_strobe,
    output logic [INDEX_W-1:0]              result_index,
    output logic signed [VALUE_W-1:0]       result_value,
    output logic                            last_result
);

    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int LEN_W = $clog2(MAX_LENGTH + 1);

    logic                       mac_active;
    logic [IDX_W-1:0]           load_slot;
    logic [IDX_W-1:0]           rd_addr_first;
    logic [IDX_W-1:0]           rd_addr_second;
    logic signed [SAMPLE_W-1:0] rd_first;
    logic signed [SAMPLE_W-1:0] rd_second;
    term_t                      term;

    // Sequencer
    clc_seq #(
        .MAX_LENGTH (MAX_LENGTH),
        .IDX_W      (IDX_W),
        .LEN_W      (LEN_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .mac_active     (mac_active),
        .busy           (busy),
        .cfg_ready      (cfg_ready),
        .load_slot      (load_slot),
        .rd_addr_first  (rd_addr_first),
        .rd_addr_second (rd_addr_second),
        .term           (term)
    );

    // Sample stores, written on each accepted beat
    clc_store #(
        .DEPTH  (MAX_LENGTH),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk            (clk),
        .wr_en          (start & ~busy),
        .wr_addr        (load_slot),
        .wr_first       (first_sample),
        .wr_second      (second_sample),
        .rd_addr_first  (rd_addr_first),
        .rd_addr_second (rd_addr_second),
        .rd_first       (rd_first),
        .rd_second      (rd_second)
    );

    // Multiply-accumulate
    clc_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .term          (term),
        .rd_first      (rd_first),
        .rd_second     (rd_second),
        .mac_active    (mac_active),
        .result_strobe (result_strobe),
        .result_index  (result_index),
        .result_value  (result_value),
        .last_result   (last_result)
    );

endmodule
`default_nettype wire

// ===== tb/centered_linear_convolution_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_linear_convolution_test
// Self-checking bench for the centred convolution block. Sample pairs are
// loaded through the start/busy port with random gaps, and the sequence length
// is rewritten between phases. Mid-load changes are included. Every result beat
// is compared field by field with a behavioural convolution kept in the bench or with a typed-in value.
// ----------------------------------------------------------------------------
module centered_linear_convolution_test;

    import clc_pkg::SAMPLE_W;
    import clc_pkg::VALUE_W;
    import clc_pkg::INDEX_W;
    import clc_pkg::CFG_W;

    localparam int MAX_LEN       = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 200;
    localparam int LIMIT_CYCLES  = 8_000_000;
    localparam int RANDOM_PAIRS  = 200;
    localparam int MAX_GAP       = 12;
    localparam int REPORT_CAP    = 30;
    localparam int DIRECTED_ROWS = 27;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_W-1:0]           length_t;

    localparam sample_t SAMPLE_MIN   = 16'sh8000;
    localparam sample_t SAMPLE_MAX   = 16'sh7FFF;
    localparam length_t RESET_LENGTH = 7'd64;

    typedef struct {
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } conv_result_t;

    typedef enum {ROW_LENGTH, ROW_PAIR, ROW_BURST} row_kind_t;

    // count: register value for ROW_LENGTH, number of pairs for ROW_BURST
    typedef struct {
        row_kind_t kind;
        int        count;
        sample_t   a;
        sample_t   b;
        bit        typed;
        longint    typed_value;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    sample_t                   first_sample;
    sample_t                   second_sample;
    logic                      cfg_valid;
    logic                      cfg_ready;
    length_t                   cfg_data;
    logic                      result_strobe;
    logic [INDEX_W-1:0]        result_index;
    logic signed [VALUE_W-1:0] result_value;
    logic                      last_result;

    // Bench copy of the block state
    sample_t      first_mem [MAX_LEN];
    sample_t      second_mem [MAX_LEN];
    int unsigned  fill_count;
    length_t      length_reg;
    conv_result_t new_results [$];
    conv_result_t awaited [$];

    int unsigned pairs_loaded    = 0;
    int unsigned runs_done       = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned shortest_run    = MAX_LEN + 1;
    int unsigned longest_run     = 0;
    int unsigned cycle_count     = 0;

    // Directed rows: single-element runs have their results typed in
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // a full load at the reset length
        '{ROW_BURST,  64, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        // zero acts as one: each beat is a complete run
        '{ROW_LENGTH, 0, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, SAMPLE_MIN, SAMPLE_MIN, 1'b1, 64'sd1073741824},
        '{ROW_PAIR,   0, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 64'sd1073676289},
        '{ROW_PAIR,   0, SAMPLE_MIN, SAMPLE_MAX, 1'b1, -64'sd1073709056},
        '{ROW_PAIR,   0, 16'sd0, 16'sd0, 1'b1, 64'sd0},
        '{ROW_PAIR,   0, -16'sd1, 16'sd1, 1'b1, -64'sd1},
        '{ROW_LENGTH, 1, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, 16'sd12345, -16'sd2, 1'b1, -64'sd24690},
        // two elements, both at the negative extreme
        '{ROW_LENGTH, 2, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 64'sd0},
        // length cut from three to two after two beats
        '{ROW_LENGTH, 3, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 64'sd0},
        '{ROW_LENGTH, 2, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, 16'sd100, -16'sd100, 1'b0, 64'sd0},
        // length cut from four to one after two beats
        '{ROW_LENGTH, 4, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, 16'sd1, 16'sd2, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, 16'sd3, 16'sd4, 1'b0, 64'sd0},
        '{ROW_LENGTH, 1, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, 16'sd5, 16'sd6, 1'b0, 64'sd0},
        // length raised from two to three after one beat
        '{ROW_LENGTH, 2, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, 16'sd7, -16'sd8, 1'b0, 64'sd0},
        '{ROW_LENGTH, 3, 16'sd0, 16'sd0, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, -16'sd9, 16'sd10, 1'b0, 64'sd0},
        '{ROW_PAIR,   0, 16'sd11, 16'sd12, 1'b0, 64'sd0}
    };

    centered_linear_convolution #(
        .MAX_LENGTH (MAX_LEN)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_sample  (first_sample),
        .second_sample (second_sample),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .result_index  (result_index),
        .result_value  (result_value),
        .last_result   (last_result)
    );

    always #6 clk = ~clk;

    function automatic int unsigned effective_length(length_t v);
        if (v == 0)
            return 1;
        if (v > MAX_LEN)
            return MAX_LEN;
        return v;
    endfunction

    // Biased towards the extremes of the Q1.15 range
    function automatic sample_t draw_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < REPORT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Store one pair; on the closing pair compute the centred section
    task automatic load_and_convolve(sample_t a, sample_t b);
        int unsigned n;
        int unsigned slot;
        int unsigned half;
        int unsigned centre;
        longint      acc;
        n    = effective_length(length_reg);
        slot = (fill_count >= MAX_LEN) ? MAX_LEN - 1 : fill_count;
        first_mem[slot]  = a;
        second_mem[slot] = b;
        if (slot + 1 < n)
        begin
            fill_count = slot + 1;
            return;
        end
        fill_count = 0;
        half       = n / 2;
        for (int unsigned x = 0; x < n; x++)
        begin
            acc    = 0;
            centre = x + half;
            for (int unsigned j = 0; j < n; j++)
                if (j <= centre && centre - j < n)
                    acc += longint'(first_mem[j]) * longint'(second_mem[centre - j]);
            new_results.push_back('{index: x[INDEX_W-1:0], value: acc[VALUE_W-1:0],
                                    last: (x + 1 == n)});
        end
        runs_done++;
        if (n < shortest_run)
            shortest_run = n;
        if (n > longest_run)
            longest_run = n;
    endtask

    // Drive one input beat; gap cycles of idling first, optionally after
    // letting every awaited result drain
    task automatic send_pair(sample_t a, sample_t b, int gap, bit drain_first,
                             bit typed, longint typed_value);
        if (drain_first && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            start <= 1'b0;
            if (drain_first)
                while (awaited.size() != 0)
                    @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        first_sample  <= a;
        second_sample <= b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        load_and_convolve(a, b);
        pairs_loaded++;
        if (typed)
        begin
            new_results.delete();
            awaited.push_back('{index: '0, value: typed_value[VALUE_W-1:0], last: 1'b1});
        end
        else
        begin
            while (new_results.size() != 0)
                awaited.push_back(new_results.pop_front());
        end
        @(negedge clk);
    endtask

    // Rewrite the length once the block has gone quiet
    task automatic write_length(length_t v);
        start <= 1'b0;
        while (awaited.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        length_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n && result_strobe === 1'b1)
        begin
            if (awaited.size() == 0)
                report_mismatch($sformatf("result beat with nothing awaited, index %0d",
                                          result_index));
            else
            begin
                want = awaited.pop_front();
                results_checked++;
                if (result_index !== want.index)
                    report_mismatch($sformatf("index %0d, want %0d",
                                              result_index, want.index));
                if (result_value !== want.value)
                    report_mismatch($sformatf("value %0d at index %0d, want %0d",
                                              result_value, want.index, want.value));
                if (last_result !== want.last)
                    report_mismatch($sformatf("last flag %b at index %0d, want %b",
                                              last_result, want.index, want.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles, %0d results still awaited",
                     cycle_count, awaited.size());
            $display("centered_linear_convolution_test: done, errors");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int unsigned n;
        int unsigned k;
        int unsigned beats;
        int unsigned pairs;
        int unsigned phase;
        bit          eager;
        length_t     v;

        rst_n         = 1'b0;
        start         = 1'b0;
        first_sample  = '0;
        second_sample = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        length_reg    = RESET_LENGTH;
        fill_count    = 0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        foreach (directed_rows[r])
        begin
            case (directed_rows[r].kind)
                ROW_LENGTH:
                    write_length(length_t'(directed_rows[r].count));
                ROW_PAIR:
                    send_pair(directed_rows[r].a, directed_rows[r].b,
                              $urandom_range(0, MAX_GAP), 1'b0,
                              directed_rows[r].typed, directed_rows[r].typed_value);
                ROW_BURST:
                    for (k = 0; k < directed_rows[r].count; k++)
                        send_pair(draw_sample(), draw_sample(),
                                  $urandom_range(0, MAX_GAP), 1'b0, 1'b0, 0);
            endcase
        end

        // Random phases: mostly whole runs, now and then a broken-off load
        pairs = 0;
        phase = 0;
        while (pairs < RANDOM_PAIRS)
        begin
            if (phase == 0)
                v = 7'd127;
            else if ($urandom_range(0, 39) == 0)
                v = length_t'($urandom_range(MAX_LEN + 1, 126));
            else if ($urandom_range(0, 9) == 0)
                v = 7'd0;
            else
                v = length_t'($urandom_range(1, 16));
            write_length(v);
            n = effective_length(v);
            if (n > 1 && $urandom_range(0, 4) == 0)
                beats = $urandom_range(1, n - 1);
            else
                beats = n * ((n > 16) ? 1 : $urandom_range(1, 3));
            eager = ($urandom_range(0, 2) == 0);
            for (k = 0; k < beats; k++)
            begin
                send_pair(draw_sample(), draw_sample(),
                          eager ? 0 : $urandom_range(0, MAX_GAP),
                          $urandom_range(0, 19) == 0, 1'b0, 0);
                pairs++;
            end
            phase++;
        end

        // Let the last run drain and watch for stray beats
        start <= 1'b0;
        while (awaited.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Loaded %0d sample pairs in %0d runs of %0d to %0d elements, over %0d phases",
                 pairs_loaded, runs_done, shortest_run, longest_run, phase);
        $display("Compared %0d result beats field by field, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("centered_linear_convolution_test: done, clean");
        else
            $display("centered_linear_convolution_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/clc_pkg.sv
hdl/clc_store.sv
hdl/clc_seq.sv
hdl/clc_mac.sv
hdl/centered_linear_convolution.sv
tb/centered_linear_convolution_test.sv
